@@ rtl/ppfm_pkg.sv @@
// shared types, constants and segment table for the peak period frequency meter
`timescale 1ns / 1ps

package ppfm_pkg;

  localparam int unsigned RATE_W    = 16;
  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned SEG_W     = 8;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned SHOWN_W   = 10;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 1'd1;

  localparam logic [RATE_W-1:0] RATE_RESET   = 16'd1000;
  localparam logic [RATE_W-1:0] SETTLE_RESET = 16'd500;

  localparam logic [SHOWN_W-1:0] DISPLAY_MAX = 10'd999;
  localparam logic [SEG_W-1:0]   POINT_BIT   = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_HUND,
    ST_TENS,
    ST_LOAD
  } ppfm_state_e;

  // segment code, bit0 = segment a
  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/ppfm_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ppfm_divider #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ppfm_pkg::RATE_W-1:0]   dividend_i,
  input  logic [COUNT_BITS-1:0]         divisor_i,
  output logic                          done_o,
  output logic [ppfm_pkg::FREQ_W-1:0]   quotient_o
);
  import ppfm_pkg::*;

  localparam int unsigned STEP_W = $clog2(RATE_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATE_W - 1);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [COUNT_BITS:0]   rem_q, rem_d;
  logic [RATE_W-1:0]     quo_q, quo_d;
  logic [COUNT_BITS-1:0] div_q, div_d;

  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  // shift next dividend bit into the partial remainder and try the subtract
  assign trial = {rem_q[COUNT_BITS-1:0], quo_q[RATE_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (run_q) begin
      rem_d  = fits ? (trial - {1'b0, div_q}) : trial;
      quo_d  = {quo_q[RATE_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/peak_period_frequency_meter.sv @@
// top level of the peak period frequency meter with seven-segment rendering
`timescale 1ns / 1ps

//  channel  | signals                                   | dir | transaction moves
//  ---------+-------------------------------------------+-----+---------------------------
//  sample   | in_valid_i, in_ready_o, sample_value_i    | in  | one converter sample
//  config   | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in  | one register write
//           | cfg_data_i                                |     |
//  result   | out_valid_o, out_ready_i, frequency_hz_o, | out | one measured period
//           | seg_hundreds_o, seg_tens_o, seg_ones_o,   |     |
//           | over_range_o                              |     |
//
//  a sample that closes no period leaves the sequencer idle, ready again the next cycle
//  a sample that closes a period starts the bit-serial divider; once it reports done,
//  the hundreds and tens steps split the digits and the load step fills the result register
//  the result register frees the sample side: the next sample is taken while a result
//  waits, and only a second result stalls in the load step until the first is taken
//  reset clears the window, counters and sequencer; registers return to rate 1000, settle 500

module peak_period_frequency_meter #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_BITS-1:0]            sample_value_i,
  // configuration channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ppfm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ppfm_pkg::RATE_W-1:0]       cfg_data_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ppfm_pkg::FREQ_W-1:0]       frequency_hz_o,
  output logic [ppfm_pkg::SEG_W-1:0]        seg_hundreds_o,
  output logic [ppfm_pkg::SEG_W-1:0]        seg_tens_o,
  output logic [ppfm_pkg::SEG_W-1:0]        seg_ones_o,
  output logic                              over_range_o
);
  import ppfm_pkg::*;

  // settle compare runs at the wider of the counter and the register
  localparam int unsigned CMP_W = (COUNT_BITS > RATE_W) ? COUNT_BITS : RATE_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_TWO = COUNT_BITS'(2);

  // configuration registers
  logic [RATE_W-1:0] rate_q;
  logic [RATE_W-1:0] settle_q;

  // peak window and counters
  logic [SAMPLE_BITS-1:0] older_q, middle_q;
  logic [COUNT_BITS-1:0]  seen_q, seen_d;
  logic [COUNT_BITS-1:0]  since_q, since_d;
  logic                   first_q, first_d;

  // sequencer
  ppfm_state_e state_q, state_d;
  logic        in_accept;
  logic        window_ok, is_peak, report;
  logic        div_start, div_done;
  logic        load_out;
  logic [COUNT_BITS-1:0] since_inc, period;
  logic [FREQ_W-1:0]     quotient;

  // digit split
  logic [FREQ_W-1:0]  freq_q;
  logic               over_q;
  logic [DIGIT_W-1:0] hund_q, tens_q, ones_q;
  logic [6:0]         rest_q;
  logic [SHOWN_W-1:0] shown;
  logic [15:0]        hund_prod;
  logic [DIGIT_W-1:0] hund_dig;
  logic [SHOWN_W-1:0] hund_part;
  logic [14:0]        tens_prod;
  logic [DIGIT_W-1:0] tens_dig;
  logic [6:0]         tens_part;

  // result register
  logic              out_valid_q;
  logic [FREQ_W-1:0] out_freq_q;
  logic [SEG_W-1:0]  out_hund_q, out_tens_q, out_ones_q;
  logic              out_over_q;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  // peak test on the window before the newest sample shifts in
  assign window_ok = (seen_q >= COUNT_TWO) &&
                     (CMP_W'(seen_q) > CMP_W'(settle_q));
  assign is_peak   = window_ok && (older_q < middle_q) && (sample_value_i < middle_q);
  assign report    = is_peak && first_q;

  // distance counter steps before the peak closes the period
  assign since_inc = !first_q ? since_q :
                     (since_q == COUNT_MAX) ? COUNT_MAX : since_q + COUNT_ONE;
  assign period    = (since_inc == '0) ? COUNT_ONE : since_inc;

  always_comb begin
    seen_d  = (seen_q == COUNT_MAX) ? COUNT_MAX : seen_q + COUNT_ONE;
    since_d = is_peak ? '0 : since_inc;
    first_d = first_q || is_peak;
  end

  ppfm_divider #(
    .COUNT_BITS (COUNT_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rate_q),
    .divisor_i  (period),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && report) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_HUND;
      end
      ST_HUND: state_d = ST_TENS;
      ST_TENS: state_d = ST_LOAD;
      ST_LOAD: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = in_valid_i && report;
      end
      ST_LOAD: load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // hundreds by reciprocal: x*41 >> 12 equals x/100 for x up to 999
  assign shown     = (quotient > FREQ_W'(DISPLAY_MAX)) ? DISPLAY_MAX : quotient[SHOWN_W-1:0];
  assign hund_prod = 16'(shown) * 16'd41;
  assign hund_dig  = hund_prod[15:12];
  assign hund_part = SHOWN_W'(hund_dig) * SHOWN_W'(100);

  // tens by reciprocal: x*205 >> 11 equals x/10 for x up to 99
  assign tens_prod = 15'(rest_q) * 15'd205;
  assign tens_dig  = tens_prod[14:11];
  assign tens_part = 7'(tens_dig) * 7'd10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= RATE_RESET;
      settle_q    <= SETTLE_RESET;
      older_q     <= '0;
      middle_q    <= '0;
      seen_q      <= '0;
      since_q     <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SAMPLE_RATE: rate_q   <= cfg_data_i;
          CFG_SETTLE:      settle_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_accept) begin
        older_q  <= middle_q;
        middle_q <= sample_value_i;
        seen_q   <= seen_d;
        since_q  <= since_d;
        first_q  <= first_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // digit datapath and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_HUND) begin
      freq_q <= quotient;
      over_q <= quotient > FREQ_W'(DISPLAY_MAX);
      hund_q <= hund_dig;
      rest_q <= 7'(shown - hund_part);
    end
    if (state_q == ST_TENS) begin
      tens_q <= tens_dig;
      ones_q <= DIGIT_W'(rest_q - tens_part);
    end
    if (load_out) begin
      out_freq_q <= freq_q;
      out_hund_q <= seg_code(hund_q);
      out_tens_q <= seg_code(tens_q);
      out_ones_q <= seg_code(ones_q) | POINT_BIT;
      out_over_q <= over_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frequency_hz_o = out_freq_q;
  assign seg_hundreds_o = out_hund_q;
  assign seg_tens_o     = out_tens_q;
  assign seg_ones_o     = out_ones_q;
  assign over_range_o   = out_over_q;

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for the peak period frequency meter
`timescale 1ns / 1ps

module tb_top;
  import ppfm_pkg::*;

  localparam int SAMPLE_W = 12;
  localparam int CNT_W = 16;
  localparam int DRAIN_PAUSE = 40;           // pause after the owed readings are taken, leave margin
  localparam longint WATCHDOG_NS = 64'd7_200_000;  // watchdog timeout, 12 ns clock

  // one measured period as it leaves the block
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [SEG_W-1:0]  hund;
    logic [SEG_W-1:0]  tens;
    logic [SEG_W-1:0]  ones;
    logic              over;
  } reading_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;   // unused on sample rows
    logic [RATE_W-1:0]     value;     // register data or sample value
    logic                  has_want;  // expected reading typed in below
    reading_t              want;
  } stim_row_t;

  localparam reading_t NO_READING = '0;

  // segment patterns for digits 0 to 9, bit0 = segment a
  localparam logic [SEG_W-1:0] SEG_LUT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // directed part: window filling, rate extremes, zero rate, plateau, smallest peak
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    // settle 0: no peak may be tested before the window holds three samples
    '{ROW_WRITE,  CFG_SETTLE,      16'd0,     1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd4095,  1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd0,     1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd4095,  1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd0,     1'b0, NO_READING},   // first peak, no reading
    '{ROW_SAMPLE, '0,              16'd4095,  1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd0,     1'b1,
      '{16'd500, 8'h6D, 8'h3F, 8'hBF, 1'b0}},                      // 1000 / 2
    // top rate: display saturates at 999 and the flag rises
    '{ROW_WRITE,  CFG_SAMPLE_RATE, 16'd50000, 1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd4095,  1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd0,     1'b1,
      '{16'd25000, 8'h6F, 8'h6F, 8'hEF, 1'b1}},
    // zero rate gives zero
    '{ROW_WRITE,  CFG_SAMPLE_RATE, 16'd0,     1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd4095,  1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd0,     1'b1,
      '{16'd0, 8'h3F, 8'h3F, 8'hBF, 1'b0}},
    // lowest rate, floor to zero
    '{ROW_WRITE,  CFG_SAMPLE_RATE, 16'd1,     1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd4095,  1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd0,     1'b0, NO_READING},
    '{ROW_WRITE,  CFG_SAMPLE_RATE, 16'd1000,  1'b0, NO_READING},
    '{ROW_WRITE,  CFG_SETTLE,      16'd1,     1'b0, NO_READING},
    // equal neighbors are no peak
    '{ROW_SAMPLE, '0,              16'd4095,  1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd4095,  1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd0,     1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd4095,  1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd0,     1'b0, NO_READING},
    // smallest possible peak
    '{ROW_SAMPLE, '0,              16'd1,     1'b0, NO_READING},
    '{ROW_SAMPLE, '0,              16'd0,     1'b0, NO_READING}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] sample_value_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [RATE_W-1:0]   cfg_data_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [FREQ_W-1:0]   frequency_hz_o;
  logic [SEG_W-1:0]    seg_hundreds_o;
  logic [SEG_W-1:0]    seg_tens_o;
  logic [SEG_W-1:0]    seg_ones_o;
  logic                over_range_o;

  // meter state mirrored by the predictor
  logic [RATE_W-1:0]   rate_reg;
  logic [RATE_W-1:0]   settle_reg;
  logic [SAMPLE_W-1:0] older_s;
  logic [SAMPLE_W-1:0] middle_s;
  logic [CNT_W-1:0]    seen_cnt;
  logic [CNT_W-1:0]    since_cnt;
  logic                peak_armed;

  reading_t pending_readings [$];   // readings still owed by the block, oldest first
  int       bad_count = 0;
  int       send_idle_pct = 0;       // chance per cycle that the sample side holds off
  int       recv_stall_pct = 0;      // chance per cycle that the result side stalls

  peak_period_frequency_meter #(
    .SAMPLE_BITS(SAMPLE_W),
    .COUNT_BITS (CNT_W)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sample_value_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .out_valid_o,
    .out_ready_i,
    .frequency_hz_o,
    .seg_hundreds_o,
    .seg_tens_o,
    .seg_ones_o,
    .over_range_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(WATCHDOG_NS);
    $display("Test completed with failures");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // one sample through the meter: slide the window, count, and on a peak
  // after the first one turn the period into a frequency and its digits
  task automatic meter_predict(input logic [SAMPLE_W-1:0] fresh, output bit hit,
                               output reading_t r);
    logic        window_ok;
    logic        is_peak;
    int unsigned period;
    int unsigned freq;
    int unsigned shown;
    window_ok = (seen_cnt >= 2) && (seen_cnt > settle_reg);
    is_peak = window_ok && (older_s < middle_s) && (fresh < middle_s);
    hit = 1'b0;
    r = NO_READING;
    if (peak_armed) since_cnt = sat_bump(since_cnt);
    if (is_peak) begin
      if (peak_armed) begin
        period = (since_cnt == 0) ? 1 : since_cnt;
        freq = rate_reg / period;
        shown = (freq > DISPLAY_MAX) ? DISPLAY_MAX : freq;
        r.freq = freq[FREQ_W-1:0];
        r.hund = SEG_LUT[shown / 100];
        r.tens = SEG_LUT[(shown / 10) % 10];
        r.ones = SEG_LUT[shown % 10] | POINT_BIT;
        r.over = (freq > DISPLAY_MAX);
        hit = 1'b1;
      end
      // the closing peak opens the next period
      peak_armed = 1'b1;
      since_cnt = '0;
    end
    older_s = middle_s;
    middle_s = fresh;
    seen_cnt = sat_bump(seen_cnt);
  endtask

  // stop both input channels, wait for every owed reading, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  // register writes happen only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_SAMPLE_RATE) rate_reg = data;
    else settle_reg = data;
  endtask

  // one sample transaction; valid may stay high into the next one
  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit use_want,
                             input reading_t want);
    bit       hit;
    reading_t r;
    cfg_valid_i <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    meter_predict(v, hit, r);
    if (use_want) pending_readings.push_back(want);
    else if (hit) pending_readings.push_back(r);
  endtask

  // mostly clean rising ramps that fall back low, so each clean ramp top is a peak;
  // the rest is plateaus, noise and flat runs that break the pattern
  task automatic run_random_phase(input int unsigned quota);
    int unsigned sent;
    int unsigned mode;
    int unsigned p;
    int unsigned base;
    int unsigned top;
    int unsigned n;
    logic [SAMPLE_W-1:0] v;
    sent = 0;
    while (sent < quota) begin
      mode = $urandom_range(0, 99);
      if (mode < 83) begin
        p = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(2, 12);
        base = $urandom_range(0, 1023);
        top = $urandom_range(2048, 4095);
        for (int k = 0; k < p; k++) begin
          send_sample(SAMPLE_W'(base + ((top - base) * k) / (p - 1)), 1'b0, NO_READING);
        end
        // repeated top: flat crest, no strict peak
        if (mode >= 75) send_sample(SAMPLE_W'(top), 1'b0, NO_READING);
        sent += p;
      end else if (mode < 93) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          send_sample(SAMPLE_W'($urandom_range(0, 4095)), 1'b0, NO_READING);
        end
        sent += n;
      end else begin
        n = $urandom_range(1, 20);
        v = SAMPLE_W'($urandom_range(0, 4095));
        repeat (n) send_sample(v, 1'b0, NO_READING);
        sent += n;
      end
    end
  endtask

  // result checker: every accepted reading against the oldest one owed
  always @(posedge clk_i) begin
    reading_t got;
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.freq = frequency_hz_o;
      got.hund = seg_hundreds_o;
      got.tens = seg_tens_o;
      got.ones = seg_ones_o;
      got.over = over_range_o;
      if (pending_readings.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: unexpected reading freq %0d seg %h %h %h over %b", $realtime,
                   got.freq, got.hund, got.tens, got.ones, got.over);
      end else begin
        want = pending_readings.pop_front();
        if (got.freq !== want.freq || got.hund !== want.hund || got.tens !== want.tens ||
            got.ones !== want.ones || got.over !== want.over) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: reading mismatch exp freq %0d seg %h %h %h over %b, got freq %0d seg %h %h %h over %b",
                     $realtime, want.freq, want.hund, want.tens, want.ones, want.over,
                     got.freq, got.hund, got.tens, got.ones, got.over);
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    // known values on every input before the first edge
    in_valid_i = 1'b0;
    sample_value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SAMPLE_RATE;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    // mirror of the reset state
    rate_reg = RATE_RESET;
    settle_reg = SETTLE_RESET;
    older_s = '0;
    middle_s = '0;
    seen_cnt = '0;
    since_cnt = '0;
    peak_armed = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table, no idling
    for (int i = 0; i < 25; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) write_reg(row.reg_idx, row.value);
      else send_sample(row.value[SAMPLE_W-1:0], row.has_want, row.want);
    end

    // random phases: clean flow, sender gaps, receiver stalls, light both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct = 9;
          recv_stall_pct = 9;
        end
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_SAMPLE_RATE, 16'd50000);
        1: write_reg(CFG_SAMPLE_RATE, 16'd1);
        2: write_reg(CFG_SAMPLE_RATE, RATE_W'($urandom_range(1000, 9000)));
        default: write_reg(CFG_SAMPLE_RATE, RATE_W'($urandom_range(1, 50000)));
      endcase
      // a settle past the current count holds off peaks for a while
      case ($urandom_range(0, 3))
        0: write_reg(CFG_SETTLE, 16'd1);
        1: write_reg(CFG_SETTLE, RATE_W'($urandom_range(1, seen_cnt + 60)));
        default: write_reg(CFG_SETTLE, RATE_W'($urandom_range(2, 10)));
      endcase
      run_random_phase(170);
    end

    // top rate with a short period, then a settle the counter cannot pass
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_SAMPLE_RATE, 16'd50000);
    write_reg(CFG_SETTLE, 16'd1);
    send_sample(SAMPLE_W'(4095), 1'b0, NO_READING);
    send_sample('0, 1'b0, NO_READING);
    // settle at the counter ceiling: peaks never qualify
    write_reg(CFG_SETTLE, 16'hFFFF);
    repeat (3) begin
      send_sample(SAMPLE_W'(4095), 1'b0, NO_READING);
      send_sample('0, 1'b0, NO_READING);
    end
    write_reg(CFG_SETTLE, 16'd1);
    repeat (3) begin
      send_sample(SAMPLE_W'(4095), 1'b0, NO_READING);
      send_sample('0, 1'b0, NO_READING);
    end

    wait_idle();
    if (bad_count == 0 && pending_readings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ peak_period_frequency_meter.f @@
rtl/ppfm_pkg.sv
rtl/ppfm_divider.sv
rtl/peak_period_frequency_meter.sv
sim/tb_top.sv
